// ===== hdl/whr_pkg.sv =====
`timescale 1ns / 1ps
// whr_pkg: shared types, constants and constant tables of the range random generator
package whr_pkg;

   // Field widths
   localparam int FRACTION_BITS = 32;
   localparam int VALUE_BITS    = 16;
   localparam int SEED_BITS     = 15;

   // Shared multiplier operand width
   localparam int MUL_BITS = 32;

   // Seed update: product of a seed and its multiplier fits in 23 bits.
   // Reciprocal shift is chosen so floor(p * recip >> shift) == p / m exactly.
   localparam int PROD_SEED_BITS = 23;
   localparam int SEED_SHIFT     = PROD_SEED_BITS + SEED_BITS;
   localparam int QUOT_SEED_BITS = 9;

   // Fraction term: s * (2^F mod m) fits in 30 bits.
   localparam int TERM_REM_BITS = 30;
   localparam int TERM_SHIFT    = TERM_REM_BITS + SEED_BITS;

   // Register indexes of the configuration port
   localparam logic REG_RANGE_LOW  = 1'b0;
   localparam logic REG_RANGE_HIGH = 1'b1;

   localparam logic [VALUE_BITS-1:0] RANGE_LOW_RESET  = VALUE_BITS'(0);
   localparam logic [VALUE_BITS-1:0] RANGE_HIGH_RESET = VALUE_BITS'(100);
   localparam logic [SEED_BITS-1:0]  SEED_RESET       = SEED_BITS'(1);

   // Seed select codes
   localparam logic [1:0] SEED_IDX_A    = 2'd0;
   localparam logic [1:0] SEED_IDX_B    = 2'd1;
   localparam logic [1:0] SEED_IDX_C    = 2'd2;
   localparam logic [1:0] SEED_IDX_LAST = SEED_IDX_C;

   // Datapath operations
   localparam logic [2:0] OP_NONE       = 3'd0;
   localparam logic [2:0] OP_SEED_MUL   = 3'd1;
   localparam logic [2:0] OP_MOD_RECIP  = 3'd2;
   localparam logic [2:0] OP_MOD_FIX    = 3'd3;
   localparam logic [2:0] OP_TERM_REM   = 3'd4;
   localparam logic [2:0] OP_TERM_RECIP = 3'd5;
   localparam logic [2:0] OP_TERM_ADD   = 3'd6;
   localparam logic [2:0] OP_SCALE      = 3'd7;

   // Generator constants
   localparam logic [63:0] MULT_A = 64'd171;
   localparam logic [63:0] MULT_B = 64'd172;
   localparam logic [63:0] MULT_C = 64'd170;
   localparam logic [63:0] MOD_A  = 64'd30269;
   localparam logic [63:0] MOD_B  = 64'd30307;
   localparam logic [63:0] MOD_C  = 64'd30323;

   localparam logic [63:0] RECIP_SEED_A = ((64'd1 << SEED_SHIFT) + MOD_A - 64'd1) / MOD_A;
   localparam logic [63:0] RECIP_SEED_B = ((64'd1 << SEED_SHIFT) + MOD_B - 64'd1) / MOD_B;
   localparam logic [63:0] RECIP_SEED_C = ((64'd1 << SEED_SHIFT) + MOD_C - 64'd1) / MOD_C;

   // 2^F = m * QUO + REM, so s * 2^F / m = s * QUO + (s * REM) / m
   localparam logic [63:0] QUO_TERM_A = (64'd1 << FRACTION_BITS) / MOD_A;
   localparam logic [63:0] QUO_TERM_B = (64'd1 << FRACTION_BITS) / MOD_B;
   localparam logic [63:0] QUO_TERM_C = (64'd1 << FRACTION_BITS) / MOD_C;
   localparam logic [63:0] REM_TERM_A = (64'd1 << FRACTION_BITS) % MOD_A;
   localparam logic [63:0] REM_TERM_B = (64'd1 << FRACTION_BITS) % MOD_B;
   localparam logic [63:0] REM_TERM_C = (64'd1 << FRACTION_BITS) % MOD_C;

   localparam logic [63:0] RECIP_TERM_A = ((64'd1 << TERM_SHIFT) + MOD_A - 64'd1) / MOD_A;
   localparam logic [63:0] RECIP_TERM_B = ((64'd1 << TERM_SHIFT) + MOD_B - 64'd1) / MOD_B;
   localparam logic [63:0] RECIP_TERM_C = ((64'd1 << TERM_SHIFT) + MOD_C - 64'd1) / MOD_C;

   typedef struct packed {
      logic                 mode;
      logic [SEED_BITS-1:0] seed_one;
      logic [SEED_BITS-1:0] seed_two;
      logic [SEED_BITS-1:0] seed_three;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic [FRACTION_BITS-1:0]     fraction;
      logic                         bad_range;
   } rsp_type;

   typedef struct packed {
      logic       accept;
      logic [2:0] op;
      logic [1:0] idx;
      logic       finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic load;
      logic out_free;
   } dp_status_type;

   function automatic logic [MUL_BITS-1:0] seed_multiplier(input logic [1:0] idx);
      case (idx)
         SEED_IDX_A: return MUL_BITS'(MULT_A);
         SEED_IDX_B: return MUL_BITS'(MULT_B);
         SEED_IDX_C: return MUL_BITS'(MULT_C);
         default:    return '0;
      endcase
   endfunction

   function automatic logic [MUL_BITS-1:0] seed_modulus(input logic [1:0] idx);
      case (idx)
         SEED_IDX_A: return MUL_BITS'(MOD_A);
         SEED_IDX_B: return MUL_BITS'(MOD_B);
         SEED_IDX_C: return MUL_BITS'(MOD_C);
         default:    return '0;
      endcase
   endfunction

   function automatic logic [MUL_BITS-1:0] seed_recip(input logic [1:0] idx);
      case (idx)
         SEED_IDX_A: return MUL_BITS'(RECIP_SEED_A);
         SEED_IDX_B: return MUL_BITS'(RECIP_SEED_B);
         SEED_IDX_C: return MUL_BITS'(RECIP_SEED_C);
         default:    return '0;
      endcase
   endfunction

   function automatic logic [MUL_BITS-1:0] term_quotient(input logic [1:0] idx);
      case (idx)
         SEED_IDX_A: return MUL_BITS'(QUO_TERM_A);
         SEED_IDX_B: return MUL_BITS'(QUO_TERM_B);
         SEED_IDX_C: return MUL_BITS'(QUO_TERM_C);
         default:    return '0;
      endcase
   endfunction

   function automatic logic [MUL_BITS-1:0] term_remainder(input logic [1:0] idx);
      case (idx)
         SEED_IDX_A: return MUL_BITS'(REM_TERM_A);
         SEED_IDX_B: return MUL_BITS'(REM_TERM_B);
         SEED_IDX_C: return MUL_BITS'(REM_TERM_C);
         default:    return '0;
      endcase
   endfunction

   function automatic logic [MUL_BITS-1:0] term_recip(input logic [1:0] idx);
      case (idx)
         SEED_IDX_A: return MUL_BITS'(RECIP_TERM_A);
         SEED_IDX_B: return MUL_BITS'(RECIP_TERM_B);
         SEED_IDX_C: return MUL_BITS'(RECIP_TERM_C);
         default:    return '0;
      endcase
   endfunction

endpackage

// ===== hdl/whr_ctrl.sv =====
`timescale 1ns / 1ps
// whr_ctrl: state machine that sequences the shared-multiplier datapath
module whr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  whr_pkg::dp_status_type status,
   output whr_pkg::ctrl_cmd_type  cmd
);

   localparam logic [3:0] ST_IDLE       = 4'd0;
   localparam logic [3:0] ST_SEED_MUL   = 4'd1;
   localparam logic [3:0] ST_MOD_RECIP  = 4'd2;
   localparam logic [3:0] ST_MOD_FIX    = 4'd3;
   localparam logic [3:0] ST_TERM_REM   = 4'd4;
   localparam logic [3:0] ST_TERM_RECIP = 4'd5;
   localparam logic [3:0] ST_TERM_ADD   = 4'd6;
   localparam logic [3:0] ST_SCALE      = 4'd7;
   localparam logic [3:0] ST_DONE       = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [1:0] idx_ff, idx_in;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      req_ready  = 1'b0;
      cmd.accept = 1'b0;
      cmd.op     = whr_pkg::OP_NONE;
      cmd.idx    = idx_ff;
      cmd.finish = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               idx_in     = whr_pkg::SEED_IDX_A;
               state_in   = status.load ? ST_DONE : ST_SEED_MUL;
            end
         end
         ST_SEED_MUL: begin
            cmd.op   = whr_pkg::OP_SEED_MUL;
            state_in = ST_MOD_RECIP;
         end
         ST_MOD_RECIP: begin
            cmd.op   = whr_pkg::OP_MOD_RECIP;
            state_in = ST_MOD_FIX;
         end
         ST_MOD_FIX: begin
            cmd.op   = whr_pkg::OP_MOD_FIX;
            state_in = ST_TERM_REM;
         end
         ST_TERM_REM: begin
            cmd.op   = whr_pkg::OP_TERM_REM;
            state_in = ST_TERM_RECIP;
         end
         ST_TERM_RECIP: begin
            cmd.op   = whr_pkg::OP_TERM_RECIP;
            state_in = ST_TERM_ADD;
         end
         ST_TERM_ADD: begin
            cmd.op = whr_pkg::OP_TERM_ADD;
            if (idx_ff == whr_pkg::SEED_IDX_LAST) begin
               state_in = ST_SCALE;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_SEED_MUL;
            end
         end
         ST_SCALE: begin
            cmd.op   = whr_pkg::OP_SCALE;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // wait for room in the output register
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= whr_pkg::SEED_IDX_A;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== hdl/whr_datapath.sv =====
`timescale 1ns / 1ps
// whr_datapath: seeds, range registers, shared multiplier and output register
module whr_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  whr_pkg::req_type                       req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output whr_pkg::rsp_type                       rsp_data,
   input  logic                                   csr_wr_en,
   input  logic                                   csr_index,
   input  logic [whr_pkg::VALUE_BITS-1:0]         csr_wdata,
   input  whr_pkg::ctrl_cmd_type                  cmd,
   output whr_pkg::dp_status_type                 status
);

   localparam int VB = whr_pkg::VALUE_BITS;
   localparam int FB = whr_pkg::FRACTION_BITS;
   localparam int SB = whr_pkg::SEED_BITS;
   localparam int MB = whr_pkg::MUL_BITS;

   logic [VB-1:0] range_low_ff, range_low_in;
   logic [VB-1:0] range_high_ff, range_high_in;
   logic [SB-1:0] seed_a_ff, seed_a_in;
   logic [SB-1:0] seed_b_ff, seed_b_in;
   logic [SB-1:0] seed_c_ff, seed_c_in;

   logic [whr_pkg::PROD_SEED_BITS-1:0] p_ff, p_in;
   logic [whr_pkg::QUOT_SEED_BITS-1:0] q_ff, q_in;
   logic [whr_pkg::TERM_REM_BITS-1:0]  x_ff, x_in;
   logic [SB-1:0]                      q2_ff, q2_in;
   logic [FB-1:0]                      acc_ff, acc_in;
   logic [VB-1:0]                      value_ff, value_in;
   logic                               bad_ff, bad_in;

   logic             rsp_valid_ff, rsp_valid_in;
   whr_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [SB-1:0]   seed_sel;
   logic [SB-1:0]   seed_new;
   logic [MB-1:0]   mul_a, mul_b;
   logic [2*MB-1:0] prod;
   logic            range_bad;
   logic [VB:0]     range_diff;
   logic [VB+1:0]   scaled;
   logic            scale_rem;

   always_comb begin
      case (cmd.idx)
         whr_pkg::SEED_IDX_A: seed_sel = seed_a_ff;
         whr_pkg::SEED_IDX_B: seed_sel = seed_b_ff;
         whr_pkg::SEED_IDX_C: seed_sel = seed_c_ff;
         default:             seed_sel = '0;
      endcase
   end

   assign range_bad  = $signed(range_low_ff) > $signed(range_high_ff);
   assign range_diff = {range_high_ff[VB-1], range_high_ff}
                       - {range_low_ff[VB-1], range_low_ff};

   // operand selection for the single multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         whr_pkg::OP_SEED_MUL: begin
            mul_a = MB'(seed_sel);
            mul_b = whr_pkg::seed_multiplier(cmd.idx);
         end
         whr_pkg::OP_MOD_RECIP: begin
            mul_a = MB'(p_ff);
            mul_b = whr_pkg::seed_recip(cmd.idx);
         end
         whr_pkg::OP_MOD_FIX: begin
            mul_a = MB'(q_ff);
            mul_b = whr_pkg::seed_modulus(cmd.idx);
         end
         whr_pkg::OP_TERM_REM: begin
            mul_a = MB'(seed_sel);
            mul_b = whr_pkg::term_remainder(cmd.idx);
         end
         whr_pkg::OP_TERM_RECIP: begin
            mul_a = MB'(x_ff);
            mul_b = whr_pkg::term_recip(cmd.idx);
         end
         whr_pkg::OP_TERM_ADD: begin
            mul_a = MB'(seed_sel);
            mul_b = whr_pkg::term_quotient(cmd.idx);
         end
         whr_pkg::OP_SCALE: begin
            mul_a = MB'(range_diff[VB-1:0]);
            mul_b = MB'(acc_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = (2*MB)'(mul_a) * (2*MB)'(mul_b);

   // remainder of the seed update: p - (p / m) * m, always below m
   assign seed_new = SB'(p_ff - prod[whr_pkg::PROD_SEED_BITS-1:0]);

   // lo + floor(len * frac), stepped toward zero when negative and inexact
   assign scale_rem = |prod[FB-1:0];
   always_comb begin
      scaled = {{2{range_low_ff[VB-1]}}, range_low_ff} + {2'b00, prod[FB +: VB]};
      if (scaled[VB+1] && scale_rem) begin
         scaled = scaled + (VB+2)'(1);
      end
   end

   always_comb begin
      range_low_in  = range_low_ff;
      range_high_in = range_high_ff;
      seed_a_in     = seed_a_ff;
      seed_b_in     = seed_b_ff;
      seed_c_in     = seed_c_ff;
      p_in          = p_ff;
      q_in          = q_ff;
      x_in          = x_ff;
      q2_in         = q2_ff;
      acc_in        = acc_ff;
      value_in      = value_ff;
      bad_in        = bad_ff;

      if (csr_wr_en) begin
         case (csr_index)
            whr_pkg::REG_RANGE_LOW:  range_low_in  = csr_wdata;
            whr_pkg::REG_RANGE_HIGH: range_high_in = csr_wdata;
            default: begin
               range_low_in = range_low_ff;
            end
         endcase
      end

      if (cmd.accept) begin
         acc_in   = '0;
         value_in = '0;
         bad_in   = 1'b0;
         if (req_data.mode) begin
            seed_a_in = req_data.seed_one;
            seed_b_in = req_data.seed_two;
            seed_c_in = req_data.seed_three;
         end
      end

      case (cmd.op)
         whr_pkg::OP_SEED_MUL: begin
            p_in = prod[whr_pkg::PROD_SEED_BITS-1:0];
         end
         whr_pkg::OP_MOD_RECIP: begin
            q_in = prod[whr_pkg::SEED_SHIFT +: whr_pkg::QUOT_SEED_BITS];
         end
         whr_pkg::OP_MOD_FIX: begin
            case (cmd.idx)
               whr_pkg::SEED_IDX_A: seed_a_in = seed_new;
               whr_pkg::SEED_IDX_B: seed_b_in = seed_new;
               whr_pkg::SEED_IDX_C: seed_c_in = seed_new;
               default: begin
                  seed_a_in = seed_a_ff;
               end
            endcase
         end
         whr_pkg::OP_TERM_REM: begin
            x_in = prod[whr_pkg::TERM_REM_BITS-1:0];
         end
         whr_pkg::OP_TERM_RECIP: begin
            q2_in = prod[whr_pkg::TERM_SHIFT +: SB];
         end
         whr_pkg::OP_TERM_ADD: begin
            acc_in = acc_ff + prod[FB-1:0] + FB'(q2_ff);
         end
         whr_pkg::OP_SCALE: begin
            bad_in   = range_bad;
            value_in = range_bad ? '0 : scaled[VB-1:0];
         end
         default: begin
            p_in = p_ff;
         end
      endcase
   end

   // output register
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.load     = req_data.mode;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.finish) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.value     = value_ff;
         rsp_data_in.fraction  = acc_ff;
         rsp_data_in.bad_range = bad_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= whr_pkg::RANGE_LOW_RESET;
         range_high_ff <= whr_pkg::RANGE_HIGH_RESET;
         seed_a_ff     <= whr_pkg::SEED_RESET;
         seed_b_ff     <= whr_pkg::SEED_RESET;
         seed_c_ff     <= whr_pkg::SEED_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         range_low_ff  <= range_low_in;
         range_high_ff <= range_high_in;
         seed_a_ff     <= seed_a_in;
         seed_b_ff     <= seed_b_in;
         seed_c_ff     <= seed_c_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff        <= p_in;
      q_ff        <= q_in;
      x_ff        <= x_in;
      q2_ff       <= q2_in;
      acc_ff      <= acc_in;
      value_ff    <= value_in;
      bad_ff      <= bad_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/wichmann_hill_range_random.sv =====
`timescale 1ns / 1ps
// wichmann_hill_range_random: top level of the range-mapped AS 183 random generator
//
// Three-seed combined multiplicative congruential generator (multipliers 171, 172,
// 170; moduli 30269, 30307, 30323). A request word with mode 0 advances the seeds
// and returns one response word: fraction is the wrapped sum of seed/modulus as
// unsigned Q0.32, and value is range_low + (range_high - range_low) * fraction,
// truncated toward zero. If range_low > range_high, bad_range is set and value is
// 0 while the seeds still advance. A request word with mode 1 loads the three seeds
// as given and returns a word of all zeros. Seeds reset to 1, range to [0, 100].
// Timing: one word is in flight at a time. A draw runs from acceptance to the
// response register as 6 multiplier passes per seed, one scaling pass and one
// write-out; a seed load goes straight to write-out. The next request is taken
// in the cycle after write-out, once the sequencer is back in its idle state.
// All arithmetic goes through one 32x32 multiplier; reductions modulo the seed
// moduli and the divisions by them use exact reciprocal multiplies, so the
// multiplier pass count sets the draw time. The response register decouples the
// two sides: a finished word waits there while the next request is accepted, and
// the block only stalls at write-out if the previous word has not been taken.
// Range registers are written through the csr port (index 0 range_low, 1
// range_high) and should only change while no request is in flight.
module wichmann_hill_range_random (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  whr_pkg::req_type               req_data,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output whr_pkg::rsp_type               rsp_data,
   // register write port
   input  logic                           csr_wr_en,
   input  logic                           csr_index,
   input  logic [whr_pkg::VALUE_BITS-1:0] csr_wdata
);

   whr_pkg::ctrl_cmd_type  cmd;
   whr_pkg::dp_status_type status;

   // sequencer: owns the request handshake and the multiplier schedule
   whr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // seeds, range registers, shared multiplier, response register
   whr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ===== hdl/whr_checker.sv =====
`timescale 1ns / 1ps
// whr_checker: port-level assertions for the range random generator, bound to the top
module whr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input whr_pkg::rsp_type rsp_data
);

   // no response word right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one word at a time: busy in the cycle after an accepted request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a word is in flight");

   // a bad range always reports value zero
   a_bad_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_range |-> rsp_data.value == '0)
      else $error("nonzero value with bad range");

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

endmodule

bind wichmann_hill_range_random whr_checker u_whr_checker (.*);

// ===== bench/wichmann_hill_range_random_tb.sv =====
`timescale 1ns / 1ps
// wichmann_hill_range_random_tb: self-checking regression of the range-mapped random generator
module wichmann_hill_range_random_tb;

   // field widths from the package
   localparam int SEED_BITS     = whr_pkg::SEED_BITS;
   localparam int VALUE_BITS    = whr_pkg::VALUE_BITS;
   localparam int FRACTION_BITS = whr_pkg::FRACTION_BITS;

   // bench sizing
   localparam int QUIET_LIMIT     = 5000;  // cycles without any word moving
   localparam int DRAIN_TAIL      = 30;    // idle clocks after the final drain
   localparam int PHASES          = 12;
   localparam int WORDS_PER_PHASE = 125;
   localparam int LONG_HOLD       = 160;   // receiver back-pressure burst

   // generator constants, kept local so the prediction stands on its own
   localparam int unsigned GEN_MULT_A = 171;
   localparam int unsigned GEN_MULT_B = 172;
   localparam int unsigned GEN_MULT_C = 170;
   localparam int unsigned GEN_MOD_A  = 30269;
   localparam int unsigned GEN_MOD_B  = 30307;
   localparam int unsigned GEN_MOD_C  = 30323;

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum logic {ROW_RANGE, ROW_WORD} row_kind_type;

   // one line of the directed plan: either a range setting or a request word,
   // with the expected value / bad_range typed in where it is obvious
   typedef struct packed {
      row_kind_type                 kind;
      logic signed [VALUE_BITS-1:0] arg_low;
      logic signed [VALUE_BITS-1:0] arg_high;
      whr_pkg::req_type             word;
      logic                         typed;
      logic signed [VALUE_BITS-1:0] want_value;
      logic                         want_bad;
   } plan_row_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   whr_pkg::req_type      req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   whr_pkg::rsp_type      rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic                  csr_index = whr_pkg::REG_RANGE_LOW;
   logic [VALUE_BITS-1:0] csr_wdata = '0;

   // predictor copy of the generator state and range registers
   logic [SEED_BITS-1:0]         gen_seed_a = SEED_BITS'(1);
   logic [SEED_BITS-1:0]         gen_seed_b = SEED_BITS'(1);
   logic [SEED_BITS-1:0]         gen_seed_c = SEED_BITS'(1);
   logic signed [VALUE_BITS-1:0] gen_low    = VALUE_BITS'(0);
   logic signed [VALUE_BITS-1:0] gen_high   = VALUE_BITS'(100);

   whr_pkg::rsp_type awaited_words[$];   // expected response words, oldest first
   whr_pkg::rsp_type oldest_word;
   int               mismatch_count  = 0;
   idle_mode_type    idle_mode       = IDLE_NONE;
   int               stall_burst_req = 0;  // set by the stimulus, taken by the receiver
   int               stall_left      = 0;

   wichmann_hill_range_random dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Predictor: one request word in, the response word it must produce out.
   // Fraction is sum of floor(seed * 2^F / m) wrapped to F bits; value is the
   // exact lo + len * fraction / 2^F truncated toward zero.
   // ---------------------------------------------------------------------------
   function automatic whr_pkg::rsp_type advance_generator(input whr_pkg::req_type w);
      whr_pkg::rsp_type r;
      logic [63:0]      sum;
      logic [63:0]      prod;
      longint           lo;
      longint           hi;
      longint           res;
      r = '0;
      if (w.mode) begin
         // seed load: taken as given, even zero or past the modulus
         gen_seed_a = w.seed_one;
         gen_seed_b = w.seed_two;
         gen_seed_c = w.seed_three;
         return r;
      end
      gen_seed_a = SEED_BITS'((GEN_MULT_A * gen_seed_a) % GEN_MOD_A);
      gen_seed_b = SEED_BITS'((GEN_MULT_B * gen_seed_b) % GEN_MOD_B);
      gen_seed_c = SEED_BITS'((GEN_MULT_C * gen_seed_c) % GEN_MOD_C);
      sum = (64'(gen_seed_a) << FRACTION_BITS) / 64'(GEN_MOD_A)
          + (64'(gen_seed_b) << FRACTION_BITS) / 64'(GEN_MOD_B)
          + (64'(gen_seed_c) << FRACTION_BITS) / 64'(GEN_MOD_C);
      r.fraction = sum[FRACTION_BITS-1:0];
      lo = gen_low;
      hi = gen_high;
      if (lo > hi) begin
         // seeds advanced and fraction reported, value forced to zero
         r.bad_range = 1'b1;
         return r;
      end
      prod = 64'(hi - lo) * 64'(r.fraction);
      res  = lo + longint'(prod >> FRACTION_BITS);
      if (res < 0 && prod[FRACTION_BITS-1:0] != '0)
         res++;  // floor went down, truncation goes toward zero
      r.value = VALUE_BITS'(res);
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Directed plan rows
   // ---------------------------------------------------------------------------
   function automatic plan_row_type row_range(input int lo, input int hi);
      plan_row_type r;
      r          = '0;
      r.kind     = ROW_RANGE;
      r.arg_low  = VALUE_BITS'(lo);
      r.arg_high = VALUE_BITS'(hi);
      return r;
   endfunction

   // a load always answers with an all-zero word
   function automatic plan_row_type row_load(input int a, input int b, input int c);
      plan_row_type r;
      r                 = '0;
      r.kind            = ROW_WORD;
      r.word.mode       = 1'b1;
      r.word.seed_one   = SEED_BITS'(a);
      r.word.seed_two   = SEED_BITS'(b);
      r.word.seed_three = SEED_BITS'(c);
      r.typed           = 1'b1;
      return r;
   endfunction

   // draws carry all-ones seed fields, which must be ignored
   function automatic plan_row_type row_draw();
      plan_row_type r;
      r                 = '0;
      r.kind            = ROW_WORD;
      r.word.seed_one   = '1;
      r.word.seed_two   = '1;
      r.word.seed_three = '1;
      return r;
   endfunction

   function automatic plan_row_type row_draw_is(input int v, input logic bad);
      plan_row_type r;
      r            = row_draw();
      r.typed      = 1'b1;
      r.want_value = VALUE_BITS'(v);
      r.want_bad   = bad;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Random stimulus
   // ---------------------------------------------------------------------------
   function automatic logic [SEED_BITS-1:0] load_seed(input int unsigned modulus);
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 8)
         return '0;
      if (pick < 16)
         return SEED_BITS'($urandom);  // anywhere in 15 bits, past the modulus too
      return SEED_BITS'($urandom_range(modulus - 1, 1));
   endfunction

   function automatic whr_pkg::req_type random_word();
      whr_pkg::req_type w;
      w.mode = ($urandom_range(99) < 12);
      if (w.mode) begin
         w.seed_one   = load_seed(GEN_MOD_A);
         w.seed_two   = load_seed(GEN_MOD_B);
         w.seed_three = load_seed(GEN_MOD_C);
      end else begin
         w.seed_one   = SEED_BITS'($urandom);
         w.seed_two   = SEED_BITS'($urandom);
         w.seed_three = SEED_BITS'($urandom);
      end
      return w;
   endfunction

   task automatic pick_range(output logic signed [VALUE_BITS-1:0] lo,
                             output logic signed [VALUE_BITS-1:0] hi);
      int a;
      int b;
      int t;
      a = $signed(VALUE_BITS'($urandom));
      b = $signed(VALUE_BITS'($urandom));
      case ($urandom_range(5))
         0: ;  // either order, so about half are bad ranges
         1: begin
            if (a > b) begin
               t = a;
               a = b;
               b = t;
            end
         end
         2: b = a;  // empty range
         3: begin
            case ($urandom_range(3))
               0: begin a = -32768; b = 32767;  end
               1: begin a = 32767;  b = -32768; end
               2: begin a = -32768; b = -32768; end
               default: begin a = 32767; b = 32767; end
            endcase
         end
         4: begin
            a = int'($urandom_range(100)) - 50;
            b = a + int'($urandom_range(20));
         end
         default: begin
            // all negative, exercises truncation toward zero
            a = -int'($urandom_range(32768, 1));
            b = a + int'($urandom_range(-1 - a));
         end
      endcase
      lo = VALUE_BITS'(a);
      hi = VALUE_BITS'(b);
   endtask

   // ---------------------------------------------------------------------------
   // Handshake helpers
   // ---------------------------------------------------------------------------
   function automatic int sender_rest_pct();
      case (idle_mode)
         IDLE_SENDER: return 52;
         IDLE_BOTH:   return 13;
         default:     return 0;
      endcase
   endfunction

   function automatic int receiver_rest_pct();
      case (idle_mode)
         IDLE_RECEIVER: return 52;
         IDLE_BOTH:     return 13;
         default:       return 0;
      endcase
   endfunction

   // valid stays up after acceptance; the next call or a drain settles it
   task automatic send_word(input whr_pkg::req_type w, input whr_pkg::rsp_type want);
      while ($urandom_range(99) < sender_rest_pct()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      awaited_words.push_back(want);
   endtask

   // sender goes quiet until every awaited word is back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_words.size() != 0);
   endtask

   // only called with nothing in flight
   task automatic set_range(input logic signed [VALUE_BITS-1:0] lo,
                            input logic signed [VALUE_BITS-1:0] hi);
      csr_wr_en <= 1'b1;
      csr_index <= whr_pkg::REG_RANGE_LOW;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= whr_pkg::REG_RANGE_HIGH;
      csr_wdata <= hi;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      gen_low  = lo;
      gen_high = hi;
   endtask

   task automatic report_field(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
      mismatch_count++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
   endtask

   // ---------------------------------------------------------------------------
   // Receiver: checks each accepted word, then decides ready for the next cycle
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_words.size() == 0) begin
               mismatch_count++;
               $display("%0t: word with none awaited: value %0d fraction %h bad_range %b",
                        $time, rsp_data.value, rsp_data.fraction, rsp_data.bad_range);
            end else begin
               oldest_word = awaited_words.pop_front();
               if (rsp_data.value !== oldest_word.value)
                  report_field("value", oldest_word.value, rsp_data.value);
               if (rsp_data.fraction !== oldest_word.fraction)
                  report_field("fraction", oldest_word.fraction, rsp_data.fraction);
               if (rsp_data.bad_range !== oldest_word.bad_range)
                  report_field("bad_range", oldest_word.bad_range, rsp_data.bad_range);
            end
         end
         if (stall_burst_req != 0) begin
            stall_left      = stall_burst_req;
            stall_burst_req = 0;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_rest_pct());
         end
      end
   end

   // watchdog: ends the run if no word moves on either side for too long
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("wichmann_hill_range_random regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   initial begin
      plan_row_type                 directed_plan[$];
      whr_pkg::req_type             word;
      whr_pkg::rsp_type             want;
      logic signed [VALUE_BITS-1:0] lo;
      logic signed [VALUE_BITS-1:0] hi;

      directed_plan = '{
         row_draw(),                          // first draw from reset seeds
         row_load(30268, 30306, 30322),       // largest legal seeds
         row_draw(),
         row_load(32767, 32767, 32767),       // seeds past their moduli
         row_draw(),
         row_draw(),
         row_load(0, 0, 0),                   // all seeds stuck at zero
         row_draw_is(0, 1'b0),                // fraction 0 -> range_low
         row_load(0, 0, 1),
         row_draw(),
         row_range(-32768, 32767),            // widest range
         row_draw(),
         row_load(0, 0, 0),
         row_draw_is(-32768, 1'b0),
         row_load(1, 1, 1),
         row_draw(),
         row_draw(),
         row_range(5, 5),                     // empty range
         row_draw_is(5, 1'b0),
         row_range(-7, -7),
         row_draw_is(-7, 1'b0),
         row_range(32767, -32768),            // bad range at the extremes
         row_draw_is(0, 1'b1),
         row_load(12345, 222, 3333),
         row_draw_is(0, 1'b1),
         row_range(-100, -1),                 // negative, truncation toward zero
         row_draw(),
         row_draw(),
         row_range(-1, 0),
         row_draw(),
         row_draw()
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_RANGE) begin
            drain_results();
            set_range(directed_plan[i].arg_low, directed_plan[i].arg_high);
         end else begin
            want = advance_generator(directed_plan[i].word);
            if (directed_plan[i].typed) begin
               want.value     = directed_plan[i].want_value;
               want.bad_range = directed_plan[i].want_bad;
            end
            send_word(directed_plan[i].word, want);
         end
      end

      // random phases: new range each phase, idling mode rotates
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         pick_range(lo, hi);
         set_range(lo, hi);
         idle_mode = idle_mode_type'(phase % 4);
         if (phase % 8 == 0)
            stall_burst_req = LONG_HOLD;  // sender keeps offering, block backs up
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if ($urandom_range(63) == 0)
               drain_results();
            word = random_word();
            send_word(word, advance_generator(word));
         end
      end

      drain_results();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (mismatch_count == 0)
         $display("wichmann_hill_range_random regression: pass");
      else
         $display("wichmann_hill_range_random regression: fail");
      $finish;
   end

endmodule
